// File: design/ghfs_pkg.sv
`default_nettype none

package ghfs_pkg;

   localparam int HEIGHT_BITS = 16;
   localparam int SUM_BITS    = HEIGHT_BITS + 2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 7;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILL_MODE    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_COUNT    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLUMN_COUNT = 2'd2;

   localparam logic [1:0]               MODE_MIN        = 2'd0;
   localparam logic [1:0]               MODE_MAX        = 2'd1;
   localparam logic [CSR_DATA_BITS-1:0] ROW_COUNT_RESET = 7'd64;
   localparam logic [CSR_DATA_BITS-1:0] COL_COUNT_RESET = 7'd64;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic                          opcode;
      logic signed [HEIGHT_BITS-1:0] cell_height;
      logic                          cell_valid;
   } ghfs_req_type;

   typedef struct packed {
      logic signed [HEIGHT_BITS-1:0] out_height;
      logic                          out_valid;
      logic                          out_padded;
      logic                          last_cell;
   } ghfs_rsp_type;

   typedef struct packed {
      logic load_accept;
      logic read_accept;
      logic index_clear;
      logic pos_clear;
      logic pos_step;
      logic rd_self;
      logic rd_nb;
      logic acc_clear;
      logic acc_take;
      logic nb_step;
      logic div_start;
      logic cell_write;
   } ghfs_cmd_type;

   typedef struct packed {
      logic load_last;
      logic read_over;
      logic read_last;
      logic self_valid;
      logic nb_exists;
      logic nb_last;
      logic acc_any;
      logic mean_mode;
      logic div_busy;
      logic pos_last;
   } ghfs_stat_type;

endpackage

`default_nettype wire

// File: design/ghfs_div.sv
`default_nettype none

module ghfs_div (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [ghfs_pkg::SUM_BITS-1:0]  dividend,
   input  wire logic [2:0]                            divisor,
   output logic                                       busy,
   output logic signed [ghfs_pkg::HEIGHT_BITS-1:0]    quotient
);
   import ghfs_pkg::*;

   localparam int STEP_BITS = $clog2(SUM_BITS + 1);

   logic                 run_ff, run_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 neg_ff, neg_in;
   logic [SUM_BITS-1:0]  mag_ff, mag_in;
   logic [2:0]           rem_ff, rem_in;
   logic [2:0]           div_ff, div_in;
   logic [3:0]           trial;
   logic [3:0]           diff;
   logic                 fits;

   // Restoring division of the magnitude, one quotient bit per cycle.
   always_comb begin
      trial  = {rem_ff, mag_ff[SUM_BITS-1]};
      diff   = trial - {1'b0, div_ff};
      fits   = (trial >= {1'b0, div_ff});
      run_in  = run_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = STEP_BITS'(SUM_BITS);
         neg_in  = dividend[SUM_BITS-1];
         mag_in  = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (run_ff) begin
         mag_in  = {mag_ff[SUM_BITS-2:0], fits};
         rem_in  = fits ? diff[2:0] : trial[2:0];
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_BITS'(1)) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign busy     = run_ff;
   assign quotient = neg_ff ? signed'(~mag_ff[HEIGHT_BITS-1:0] + 1'b1)
                            : signed'(mag_ff[HEIGHT_BITS-1:0]);

endmodule

`default_nettype wire

// File: design/ghfs_ctrl.sv
`default_nettype none

module ghfs_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic                    opcode,
   input  wire ghfs_pkg::ghfs_stat_type stat,
   output ghfs_pkg::ghfs_cmd_type       cmd,
   output logic                         busy
);
   import ghfs_pkg::*;

   typedef enum logic [10:0] {
      S_LOAD     = 11'b000_0000_0001,
      S_READ     = 11'b000_0000_0010,
      S_SW_START = 11'b000_0000_0100,
      S_SELF_RD  = 11'b000_0000_1000,
      S_SELF_CHK = 11'b000_0001_0000,
      S_NB_RD    = 11'b000_0010_0000,
      S_NB_TAKE  = 11'b000_0100_0000,
      S_NB_DONE  = 11'b000_1000_0000,
      S_DIV      = 11'b001_0000_0000,
      S_WRITE    = 11'b010_0000_0000,
      S_ADVANCE  = 11'b100_0000_0000
   } ghfs_state_type;

   ghfs_state_type state_ff, state_in;
   logic           changed_ff, changed_in;
   logic           has_value_ff, has_value_in;

   always_comb begin
      state_in     = state_ff;
      changed_in   = changed_ff;
      has_value_in = has_value_ff;
      cmd          = '0;
      busy         = 1'b1;
      unique case (state_ff)
         S_LOAD: begin
            busy = 1'b0;
            if (start && (opcode == OP_LOAD)) begin
               cmd.load_accept = 1'b1;
               if (stat.load_last) begin
                  state_in = S_SW_START;
               end
            end
         end
         S_READ: begin
            busy = 1'b0;
            if (start && (opcode == OP_READ)) begin
               if (stat.read_over) begin
                  cmd.index_clear = 1'b1;
                  state_in        = S_LOAD;
               end else begin
                  cmd.read_accept = 1'b1;
                  if (stat.read_last) begin
                     cmd.index_clear = 1'b1;
                     state_in        = S_LOAD;
                  end
               end
            end
         end
         S_SW_START: begin
            cmd.pos_clear = 1'b1;
            changed_in    = 1'b0;
            has_value_in  = 1'b0;
            state_in      = S_SELF_RD;
         end
         S_SELF_RD: begin
            cmd.rd_self = 1'b1;
            state_in    = S_SELF_CHK;
         end
         S_SELF_CHK: begin
            if (stat.self_valid) begin
               has_value_in = 1'b1;
               state_in     = S_ADVANCE;
            end else begin
               cmd.acc_clear = 1'b1;
               state_in      = S_NB_RD;
            end
         end
         S_NB_RD: begin
            if (stat.nb_exists) begin
               cmd.rd_nb = 1'b1;
               state_in  = S_NB_TAKE;
            end else if (stat.nb_last) begin
               state_in = S_NB_DONE;
            end else begin
               cmd.nb_step = 1'b1;
            end
         end
         S_NB_TAKE: begin
            cmd.acc_take = 1'b1;
            if (stat.nb_last) begin
               state_in = S_NB_DONE;
            end else begin
               cmd.nb_step = 1'b1;
               state_in    = S_NB_RD;
            end
         end
         S_NB_DONE: begin
            if (!stat.acc_any) begin
               state_in = S_ADVANCE;
            end else if (stat.mean_mode) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_DIV: begin
            if (!stat.div_busy) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.cell_write = 1'b1;
            changed_in     = 1'b1;
            state_in       = S_ADVANCE;
         end
         S_ADVANCE: begin
            if (stat.pos_last) begin
               if (changed_ff && has_value_ff) begin
                  state_in = S_SW_START;
               end else begin
                  cmd.index_clear = 1'b1;
                  state_in        = S_READ;
               end
            end else begin
               cmd.pos_step = 1'b1;
               state_in     = S_SELF_RD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         changed_ff   <= 1'b0;
         has_value_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         changed_ff   <= changed_in;
         has_value_ff <= has_value_in;
      end
   end

endmodule

`default_nettype wire

// File: design/ghfs_dp.sv
`default_nettype none

module ghfs_dp #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire ghfs_pkg::ghfs_cmd_type                   cmd,
   output ghfs_pkg::ghfs_stat_type                       stat,
   input  wire ghfs_pkg::ghfs_req_type                   req_payload,
   input  wire logic                                     csr_write_enable,
   input  wire logic [ghfs_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  wire logic [ghfs_pkg::CSR_DATA_BITS-1:0]       csr_write_data,
   output logic                                          rsp_strobe,
   output ghfs_pkg::ghfs_rsp_type                        rsp_payload
);
   import ghfs_pkg::*;

   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int IW    = $clog2(CELLS + 1);
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int RBW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CBW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   localparam logic [1:0] NB_WEST  = 2'd0;
   localparam logic [1:0] NB_EAST  = 2'd1;
   localparam logic [1:0] NB_NORTH = 2'd2;
   localparam logic [1:0] NB_SOUTH = 2'd3;

   typedef struct packed {
      logic                          padded;
      logic                          valid;
      logic signed [HEIGHT_BITS-1:0] height;
   } ghfs_entry_type;

   ghfs_entry_type mem [CELLS];

   logic [1:0]               mode_ff;
   logic [CSR_DATA_BITS-1:0] row_count_ff;
   logic [CSR_DATA_BITS-1:0] col_count_ff;
   logic [IW-1:0]            load_index_ff;
   logic [IW-1:0]            read_index_ff;
   logic [RBW-1:0]           row_ff;
   logic [CBW-1:0]           col_ff;
   logic [AW-1:0]            idx_ff;
   logic [1:0]               nb_sel_ff;
   logic                     any_ff;
   logic signed [HEIGHT_BITS-1:0] best_ff;
   logic signed [SUM_BITS-1:0]    sum_ff;
   logic [2:0]               cnt_ff;
   ghfs_entry_type           rd_ff;
   logic                     last_ff;
   logic                     strobe_ff;

   logic [RW-1:0]            nr;
   logic [CW-1:0]            nc;
   logic [IW-1:0]            total;
   logic                     row_last;
   logic                     col_last;
   logic                     nb_exists;
   logic [AW-1:0]            nb_addr;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   ghfs_entry_type           wr_data;
   logic                     load_room;
   logic                     mean_mode;
   logic signed [HEIGHT_BITS-1:0] rd_height;
   logic signed [HEIGHT_BITS-1:0] fill_value;
   logic                     div_busy;
   logic signed [HEIGHT_BITS-1:0] quotient;

   assign nr = (row_count_ff == '0) ? RW'(1) :
               (int'(row_count_ff) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(row_count_ff);
   assign nc = (col_count_ff == '0) ? CW'(1) :
               (int'(col_count_ff) > MAX_COLS) ? CW'(MAX_COLS) : CW'(col_count_ff);
   assign total = IW'(int'(nr) * int'(nc));

   assign row_last  = (int'(row_ff) + 1) >= int'(nr);
   assign col_last  = (int'(col_ff) + 1) >= int'(nc);
   assign load_room = int'(load_index_ff) < int'(total);
   assign mean_mode = !((mode_ff == MODE_MIN) || (mode_ff == MODE_MAX));
   assign rd_height = rd_ff.height;

   always_comb begin
      unique case (nb_sel_ff)
         NB_WEST: begin
            nb_exists = (col_ff != '0);
            nb_addr   = idx_ff - AW'(nr);
         end
         NB_EAST: begin
            nb_exists = !col_last;
            nb_addr   = idx_ff + AW'(nr);
         end
         NB_NORTH: begin
            nb_exists = (row_ff != '0);
            nb_addr   = idx_ff - AW'(1);
         end
         NB_SOUTH: begin
            nb_exists = !row_last;
            nb_addr   = idx_ff + AW'(1);
         end
         default: begin
            nb_exists = 1'b0;
            nb_addr   = idx_ff;
         end
      endcase
   end

   assign fill_value = mean_mode ? quotient : best_ff;

   always_comb begin
      rd_en   = cmd.read_accept || cmd.rd_self || cmd.rd_nb;
      rd_addr = cmd.read_accept ? read_index_ff[AW-1:0] :
                cmd.rd_nb       ? nb_addr : idx_ff;
      wr_en   = cmd.cell_write || (cmd.load_accept && load_room);
      if (cmd.cell_write) begin
         wr_addr        = idx_ff;
         wr_data.padded = 1'b1;
         wr_data.valid  = 1'b1;
         wr_data.height = fill_value;
      end else begin
         wr_addr        = load_index_ff[AW-1:0];
         wr_data.padded = 1'b0;
         wr_data.valid  = req_payload.cell_valid;
         wr_data.height = req_payload.cell_height;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_MIN;
         row_count_ff  <= ROW_COUNT_RESET;
         col_count_ff  <= COL_COUNT_RESET;
         load_index_ff <= '0;
         read_index_ff <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_FILL_MODE:    mode_ff      <= csr_write_data[1:0];
               CSR_ROW_COUNT:    row_count_ff <= csr_write_data;
               CSR_COLUMN_COUNT: col_count_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (cmd.index_clear) begin
            load_index_ff <= '0;
            read_index_ff <= '0;
         end else begin
            if (cmd.load_accept && load_room) begin
               load_index_ff <= load_index_ff + 1'b1;
            end
            if (cmd.read_accept) begin
               read_index_ff <= read_index_ff + 1'b1;
            end
         end
         strobe_ff <= cmd.read_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_accept) begin
         last_ff <= (int'(read_index_ff) + 1) >= int'(total);
      end
      if (cmd.pos_clear) begin
         row_ff <= '0;
         col_ff <= '0;
         idx_ff <= '0;
      end else if (cmd.pos_step) begin
         idx_ff <= idx_ff + 1'b1;
         if (row_last) begin
            row_ff <= '0;
            col_ff <= col_ff + 1'b1;
         end else begin
            row_ff <= row_ff + 1'b1;
         end
      end
      if (cmd.acc_clear) begin
         nb_sel_ff <= NB_WEST;
         any_ff    <= 1'b0;
         sum_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         if (cmd.nb_step) begin
            nb_sel_ff <= nb_sel_ff + 1'b1;
         end
         if (cmd.acc_take && rd_ff.valid) begin
            any_ff <= 1'b1;
            sum_ff <= sum_ff + {{(SUM_BITS - HEIGHT_BITS){rd_height[HEIGHT_BITS-1]}}, rd_height};
            cnt_ff <= cnt_ff + 1'b1;
            if (!any_ff) begin
               best_ff <= rd_height;
            end else begin
               case (mode_ff)
                  MODE_MIN: begin
                     if (rd_height < best_ff) begin
                        best_ff <= rd_height;
                     end
                  end
                  MODE_MAX: begin
                     if (rd_height > best_ff) begin
                        best_ff <= rd_height;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   ghfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      stat.load_last  = (int'(load_index_ff) + 1) >= int'(total);
      stat.read_over  = int'(read_index_ff) >= int'(total);
      stat.read_last  = (int'(read_index_ff) + 1) >= int'(total);
      stat.self_valid = rd_ff.valid;
      stat.nb_exists  = nb_exists;
      stat.nb_last    = (nb_sel_ff == NB_SOUTH);
      stat.acc_any    = any_ff;
      stat.mean_mode  = mean_mode;
      stat.div_busy   = div_busy;
      stat.pos_last   = row_last && col_last;
   end

   assign rsp_strobe             = strobe_ff;
   assign rsp_payload.out_height = rd_ff.height;
   assign rsp_payload.out_valid  = rd_ff.valid;
   assign rsp_payload.out_padded = rd_ff.padded;
   assign rsp_payload.last_cell  = last_ff;

endmodule

`default_nettype wire

// File: design/grid_hole_fill_sweep.sv
`default_nettype none

// Height grid hole filler. Configure fill_mode, row_count and column_count through the
// csr_ write port while the block is idle. Send load beats (opcode load) with start while
// busy is low, one cell per cycle, in column-major order with the row index fastest.
// The last load beat starts the fill sweeps and busy rises on the next cycle.
// Each sweep first clears its position and then visits every cell: a valid cell is read
// and kept, while a hole reads each existing neighbor and, if any of them is valid, is
// written with a fill, in mean mode after the bit-serial divider. Sweeps repeat until
// one pass fills nothing, so the sweep time grows with the widest run of holes. Busy then
// falls and read beats (opcode read) are taken one per cycle; each returns its cell on
// rsp_payload in the next cycle, marked by rsp_strobe for that single cycle. There is no
// backpressure on the result side, so the receiver must take every beat as it is shown.
// last_cell marks the final cell, after which the block is ready for a new grid. Beats of
// the wrong kind are dropped silently. Synchronous reset returns the block to loading
// with default registers; the cell memory is not cleared, and every cell is rewritten by
// the loads of the next grid.
module grid_hole_fill_sweep #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire ghfs_pkg::ghfs_req_type              req_payload,
   output logic                                     rsp_strobe,
   output ghfs_pkg::ghfs_rsp_type                   rsp_payload,
   input  wire logic                                csr_write_enable,
   input  wire logic [ghfs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ghfs_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import ghfs_pkg::*;

   ghfs_cmd_type  cmd;
   ghfs_stat_type stat;

   ghfs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_payload.opcode),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   ghfs_dp #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_payload      (rsp_payload)
   );

endmodule

`default_nettype wire

// File: design/ghfs_checker.sv
`default_nettype none

module ghfs_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic                                busy,
   input  wire ghfs_pkg::ghfs_req_type              req_payload,
   input  wire logic                                rsp_strobe,
   input  wire ghfs_pkg::ghfs_rsp_type              rsp_payload
);
   import ghfs_pkg::*;

   // A result beat only follows an accepted read beat.
   a_strobe_after_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && (req_payload.opcode == OP_READ)))
      else $error("result beat without a preceding read beat");

   // A load beat never produces a result.
   a_no_result_for_load: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_payload.opcode == OP_LOAD)) |=> !rsp_strobe)
      else $error("result beat after a load beat");

   // After the final cell the block is back to loading, so no result can follow at once.
   a_last_cell_ends_grid: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.last_cell) |=> !rsp_strobe)
      else $error("result beat directly after the final cell");

   // Reset leaves the block idle and silent.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("block not idle after reset");

endmodule

bind grid_hole_fill_sweep ghfs_checker u_ghfs_checker (.*);

`default_nettype wire
